/* sv/assert_macros.svh */
// Assertion helpers shared by the decompressor modules.
// Each macro takes a label, the clock, the reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* sv/lz77td_pkg.sv */
package lz77td_pkg;

   // History store geometry; the depth is a power of two so pointers wrap freely.
   localparam int HIST_DEPTH  = 65536;
   localparam int HIST_ADDR_W = $clog2(HIST_DEPTH);

   // Decompressed bytes carried by one result.
   localparam int LANES      = 4;
   localparam int LANE_IDX_W = $clog2(LANES);
   localparam int LANE_CNT_W = $clog2(LANES + 1);

   // Flag byte value that opens a copy token.
   localparam logic [7:0] FLAG_COPY = 8'd1;

   // Saturation value of the produced-byte count.
   localparam logic [15:0] PRODUCED_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_TRUNC = 2'd1,
      ERR_DIST  = 2'd2
   } err_code_type;

   typedef enum logic [2:0] {
      PH_FLAG = 3'd0,
      PH_LIT  = 3'd1,
      PH_DHI  = 3'd2,
      PH_DLO  = 3'd3,
      PH_LEN  = 3'd4,
      PH_SKIP = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
      logic [7:0] out_byte3;
      logic [2:0] out_count;
      logic       run_last;
      logic       stream_end;
      logic [1:0] error_code;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         latch_in;
      logic         load_dhi;
      logic         load_dlo;
      logic         write_lit;
      logic         load_len;
      logic         copy_rd;
      logic         copy_wr;
      logic         emit;
      err_code_type emit_err;
      logic         emit_final;
      logic         clear_stream;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       in_last;
      logic       is_copy_flag;
      logic       len_zero;
      logic       dist_bad;
      logic       rem_is_one;
      logic       lane_last_slot;
      logic       rsp_free;
   } status_type;

endpackage

/* sv/lz77td_ctrl.sv */
`include "assert_macros.svh"

module lz77td_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lz77td_pkg::status_type status,
   output lz77td_pkg::cmd_type    cmd
);

   lz77td_pkg::state_type    state_ff, state_in;
   lz77td_pkg::phase_type    phase_ff, phase_in;
   lz77td_pkg::err_code_type err_ff, err_in;
   logic                     final_ff, final_in;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lz77td_pkg::ST_IDLE;
         phase_ff <= lz77td_pkg::PH_FLAG;
         err_ff   <= lz77td_pkg::ERR_NONE;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         err_ff   <= err_in;
         final_ff <= final_in;
      end
   end

   // Next state, parse phase and pending result flags.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      err_in   = err_ff;
      final_in = final_ff;
      case (state_ff)
         lz77td_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = lz77td_pkg::ST_DECODE;
            end
         end
         lz77td_pkg::ST_DECODE: begin
            err_in   = lz77td_pkg::ERR_NONE;
            final_in = 1'b1;
            state_in = lz77td_pkg::ST_IDLE;
            case (phase_ff)
               lz77td_pkg::PH_LIT: begin
                  phase_in = lz77td_pkg::PH_FLAG;
                  state_in = lz77td_pkg::ST_EMIT;
               end
               lz77td_pkg::PH_DHI: begin
                  if (status.in_last) begin
                     err_in   = lz77td_pkg::ERR_TRUNC;
                     state_in = lz77td_pkg::ST_EMIT;
                  end else begin
                     phase_in = lz77td_pkg::PH_DLO;
                  end
               end
               lz77td_pkg::PH_DLO: begin
                  if (status.in_last) begin
                     err_in   = lz77td_pkg::ERR_TRUNC;
                     state_in = lz77td_pkg::ST_EMIT;
                  end else begin
                     phase_in = lz77td_pkg::PH_LEN;
                  end
               end
               lz77td_pkg::PH_LEN: begin
                  phase_in = lz77td_pkg::PH_FLAG;
                  if (status.dist_bad) begin
                     err_in   = lz77td_pkg::ERR_DIST;
                     state_in = lz77td_pkg::ST_EMIT;
                  end else if (!status.len_zero) begin
                     state_in = lz77td_pkg::ST_COPY_RD;
                  end else if (status.in_last) begin
                     state_in = lz77td_pkg::ST_EMIT;
                  end
               end
               lz77td_pkg::PH_SKIP: begin
                  if (status.in_last) begin
                     state_in = lz77td_pkg::ST_EMIT;
                  end
               end
               default: begin
                  // Expecting a flag byte; unused phase codes behave the same.
                  if (status.in_last) begin
                     err_in   = lz77td_pkg::ERR_TRUNC;
                     state_in = lz77td_pkg::ST_EMIT;
                  end else if (status.is_copy_flag) begin
                     phase_in = lz77td_pkg::PH_DHI;
                  end else begin
                     phase_in = lz77td_pkg::PH_LIT;
                  end
               end
            endcase
         end
         lz77td_pkg::ST_COPY_RD: begin
            state_in = lz77td_pkg::ST_COPY_WR;
         end
         lz77td_pkg::ST_COPY_WR: begin
            if (status.rem_is_one) begin
               final_in = 1'b1;
               state_in = lz77td_pkg::ST_EMIT;
            end else if (status.lane_last_slot) begin
               final_in = 1'b0;
               state_in = lz77td_pkg::ST_EMIT;
            end else begin
               state_in = lz77td_pkg::ST_COPY_RD;
            end
         end
         lz77td_pkg::ST_EMIT: begin
            if (status.rsp_free) begin
               if (!final_ff) begin
                  state_in = lz77td_pkg::ST_COPY_RD;
               end else begin
                  state_in = lz77td_pkg::ST_IDLE;
                  if (status.in_last) begin
                     phase_in = lz77td_pkg::PH_FLAG;
                  end else if (err_ff != lz77td_pkg::ERR_NONE) begin
                     phase_in = lz77td_pkg::PH_SKIP;
                  end
               end
            end
         end
         default: begin
            state_in = lz77td_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd            = '0;
      cmd.emit_err   = err_ff;
      cmd.emit_final = final_ff;
      req_stall      = (state_ff != lz77td_pkg::ST_IDLE);
      case (state_ff)
         lz77td_pkg::ST_IDLE: begin
            cmd.latch_in = req_valid;
         end
         lz77td_pkg::ST_DECODE: begin
            case (phase_ff)
               lz77td_pkg::PH_LIT: cmd.write_lit = 1'b1;
               lz77td_pkg::PH_DHI: cmd.load_dhi = 1'b1;
               lz77td_pkg::PH_DLO: cmd.load_dlo = 1'b1;
               lz77td_pkg::PH_LEN: cmd.load_len = !status.dist_bad;
               default: cmd = cmd;
            endcase
         end
         lz77td_pkg::ST_COPY_RD: begin
            cmd.copy_rd = 1'b1;
         end
         lz77td_pkg::ST_COPY_WR: begin
            cmd.copy_wr = 1'b1;
         end
         lz77td_pkg::ST_EMIT: begin
            cmd.emit         = status.rsp_free;
            cmd.clear_stream = status.rsp_free && final_ff && status.in_last;
         end
         default: begin
            cmd = cmd;
         end
      endcase
   end

   // A history read always completes with a write in the following cycle.
   `ASSERT_NEXT(a_rd_then_wr, clock, reset, state_ff == lz77td_pkg::ST_COPY_RD,
                state_ff == lz77td_pkg::ST_COPY_WR)
   // Input is discarded only after an invalid distance was reported.
   `ASSERT_IMPL(a_skip_after_error, clock, reset,
                phase_ff != lz77td_pkg::PH_SKIP && phase_in == lz77td_pkg::PH_SKIP,
                err_ff == lz77td_pkg::ERR_DIST)
   // A pending result that is not the last of its byte only follows a copy.
   `ASSERT_NEXT(a_partial_from_copy, clock, reset,
                state_ff == lz77td_pkg::ST_EMIT && !final_ff && status.rsp_free,
                state_ff == lz77td_pkg::ST_COPY_RD)

endmodule

/* sv/lz77td_dp.sv */
`include "assert_macros.svh"

module lz77td_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  lz77td_pkg::req_payload_type req_data,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output lz77td_pkg::rsp_payload_type rsp_data,
   input  lz77td_pkg::cmd_type         cmd,
   output lz77td_pkg::status_type      status
);

   logic [7:0] history_mem [lz77td_pkg::HIST_DEPTH];

   logic [7:0]                          byte_ff;
   logic                                last_ff;
   logic [15:0]                         dist_ff, dist_in;
   logic [15:0]                         produced_ff, produced_in;
   logic [lz77td_pkg::HIST_ADDR_W-1:0]  wp_ff, wp_in;
   logic [7:0]                          rem_ff;
   logic [7:0]                          rd_data_ff;
   logic [7:0]                          lane_ff [lz77td_pkg::LANES];
   logic [lz77td_pkg::LANE_CNT_W-1:0]   lane_fill_ff, lane_fill_in;
   logic                                rsp_valid_ff;
   lz77td_pkg::rsp_payload_type         rsp_ff;

   logic                                push;
   logic [7:0]                          push_byte;
   logic [lz77td_pkg::HIST_ADDR_W-1:0]  rd_addr;
   logic [7:0]                          emit_bytes [lz77td_pkg::LANES];

   // Byte that enters the history and the lane buffer this cycle.
   assign push      = cmd.write_lit || cmd.copy_wr;
   assign push_byte = cmd.copy_wr ? rd_data_ff : byte_ff;
   assign rd_addr   = wp_ff - dist_ff[lz77td_pkg::HIST_ADDR_W-1:0];

   // History store: one write and one registered read port.
   always_ff @(posedge clock) begin
      if (push) begin
         history_mem[wp_ff] <= push_byte;
      end
      if (cmd.copy_rd) begin
         rd_data_ff <= history_mem[rd_addr];
      end
   end

   // Latched input transaction and remaining copy length.
   always_ff @(posedge clock) begin
      if (cmd.latch_in) begin
         byte_ff <= req_data.in_byte;
         last_ff <= req_data.stream_last;
      end
      if (cmd.load_len) begin
         rem_ff <= byte_ff;
      end else if (cmd.copy_wr) begin
         rem_ff <= rem_ff - 8'd1;
      end
   end

   // Token and stream state.
   always_comb begin
      dist_in     = dist_ff;
      produced_in = produced_ff;
      wp_in       = wp_ff;
      if (cmd.load_dhi) begin
         dist_in = {byte_ff, 8'd0};
      end else if (cmd.load_dlo) begin
         dist_in = {dist_ff[15:8], byte_ff};
      end
      if (push) begin
         wp_in = wp_ff + lz77td_pkg::HIST_ADDR_W'(1);
         if (produced_ff != lz77td_pkg::PRODUCED_MAX) begin
            produced_in = produced_ff + 16'd1;
         end
      end
      if (cmd.clear_stream) begin
         dist_in     = '0;
         produced_in = '0;
         wp_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff     <= '0;
         produced_ff <= '0;
         wp_ff       <= '0;
      end else begin
         dist_ff     <= dist_in;
         produced_ff <= produced_in;
         wp_ff       <= wp_in;
      end
   end

   // Lane buffer gathering bytes for the next result.
   always_comb begin
      lane_fill_in = lane_fill_ff;
      if (cmd.emit) begin
         lane_fill_in = '0;
      end else if (push) begin
         lane_fill_in = lane_fill_ff + lz77td_pkg::LANE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_fill_ff <= '0;
      end else begin
         lane_fill_ff <= lane_fill_in;
      end
      if (push) begin
         lane_ff[lane_fill_ff[lz77td_pkg::LANE_IDX_W-1:0]] <= push_byte;
      end
   end

   // Unfilled lanes read as zero.
   always_comb begin
      for (int j = 0; j < lz77td_pkg::LANES; j++) begin
         emit_bytes[j] = (j < int'(lane_fill_ff)) ? lane_ff[j] : 8'd0;
      end
   end

   // Output register; it is reloaded only when it is empty or the held transaction leaves.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_ff.out_byte0  <= emit_bytes[0];
         rsp_ff.out_byte1  <= emit_bytes[1];
         rsp_ff.out_byte2  <= emit_bytes[2];
         rsp_ff.out_byte3  <= emit_bytes[3];
         rsp_ff.out_count  <= 3'(lane_fill_ff);
         rsp_ff.run_last   <= cmd.emit_final;
         rsp_ff.stream_end <= cmd.emit_final && last_ff;
         rsp_ff.error_code <= cmd.emit_err;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status for the controller.
   always_comb begin
      status.in_last        = last_ff;
      status.is_copy_flag   = (byte_ff == lz77td_pkg::FLAG_COPY);
      status.len_zero       = (byte_ff == 8'd0);
      status.dist_bad       = (dist_ff == 16'd0) || (dist_ff > produced_ff) ||
                              (32'(dist_ff) > lz77td_pkg::HIST_DEPTH);
      status.rem_is_one     = (rem_ff == 8'd1);
      status.lane_last_slot = (lane_fill_ff == lz77td_pkg::LANE_CNT_W'(lz77td_pkg::LANES - 1));
      status.rsp_free       = !rsp_valid_ff || !rsp_stall;
   end

   `ASSERT_IMPL(a_lane_bound, clock, reset, 1'b1,
                lane_fill_ff <= lz77td_pkg::LANE_CNT_W'(lz77td_pkg::LANES))
   `ASSERT_NEXT(a_error_empty, clock, reset,
                cmd.emit && cmd.emit_err != lz77td_pkg::ERR_NONE,
                rsp_valid_ff && rsp_ff.out_count == 3'd0)
   `ASSERT_NEXT(a_stream_cleared, clock, reset, cmd.clear_stream,
                produced_ff == 16'd0 && wp_ff == '0 && dist_ff == 16'd0)

endmodule

/* sv/lz77_token_decompressor.sv */
// A transaction is accepted in IDLE and decoded in the next; a byte that yields no
// data returns to IDLE, while a literal, an error or an empty end-of-stream result
// goes through EMIT. A copy moves one byte at a time on the single history read port
// (a read state, then a write state) and enters EMIT whenever the lanes fill or the
// copy ends; output stalls keep it in EMIT. Synchronous active-high reset clears the
// parser, distance, counts and write pointer; the history store is left as it is.
module lz77_token_decompressor (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  lz77td_pkg::req_payload_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output lz77td_pkg::rsp_payload_type rsp_data
);

   lz77td_pkg::cmd_type    cmd;
   lz77td_pkg::status_type status;

   // Token parser and copy sequencer.
   lz77td_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // History store, lane buffer and output register.
   lz77td_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

/* bench/lz77_token_decompressor_test.sv */
`timescale 1ns / 100ps

module lz77_token_decompressor_test;

   localparam int RESULTS_PER_BYTE_MAX = 64;
   localparam int LONG_HOLD_CYCLES     = 300;
   localparam int SETTLE_CYCLES        = 600;
   localparam int ITEMS_PER_PHASE      = 85;

   // Results that can be read straight off the token stream.
   localparam lz77td_pkg::rsp_payload_type NO_FIXED     = '0;
   localparam lz77td_pkg::rsp_payload_type TRUNC_AT_END =
      '{8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1'b1, 1'b1, lz77td_pkg::ERR_TRUNC};
   localparam lz77td_pkg::rsp_payload_type BAD_DISTANCE =
      '{8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1'b1, 1'b0, lz77td_pkg::ERR_DIST};
   localparam lz77td_pkg::rsp_payload_type SKIPPED_END  =
      '{8'h00, 8'h00, 8'h00, 8'h00, 3'd0, 1'b1, 1'b1, lz77td_pkg::ERR_NONE};

   typedef struct packed {
      logic [7:0]                  token_byte;
      logic                        last;
      logic                        fixed;
      lz77td_pkg::rsp_payload_type want;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [25] = '{
      '{8'h00, 1'b1, 1'b1, TRUNC_AT_END},   // stream ends on its flag byte
      '{8'h00, 1'b0, 1'b0, NO_FIXED},       // literal 0xFF
      '{8'hFF, 1'b0, 1'b0, NO_FIXED},
      '{8'hFE, 1'b0, 1'b0, NO_FIXED},       // literal 0x00
      '{8'h00, 1'b0, 1'b0, NO_FIXED},
      '{8'h01, 1'b0, 1'b0, NO_FIXED},       // copy overlapping its own output
      '{8'h00, 1'b0, 1'b0, NO_FIXED},
      '{8'h02, 1'b0, 1'b0, NO_FIXED},
      '{8'h05, 1'b0, 1'b0, NO_FIXED},
      '{8'h01, 1'b0, 1'b0, NO_FIXED},       // copy of length zero
      '{8'h00, 1'b0, 1'b0, NO_FIXED},
      '{8'h01, 1'b0, 1'b0, NO_FIXED},
      '{8'h00, 1'b0, 1'b0, NO_FIXED},
      '{8'h01, 1'b0, 1'b0, NO_FIXED},       // longest copy, 64 results
      '{8'h00, 1'b0, 1'b0, NO_FIXED},
      '{8'h03, 1'b0, 1'b0, NO_FIXED},
      '{8'hFF, 1'b0, 1'b0, NO_FIXED},
      '{8'h01, 1'b0, 1'b0, NO_FIXED},       // distance beyond the bytes produced
      '{8'hFF, 1'b0, 1'b0, NO_FIXED},
      '{8'hFF, 1'b0, 1'b0, NO_FIXED},
      '{8'h07, 1'b0, 1'b1, BAD_DISTANCE},
      '{8'h80, 1'b0, 1'b0, NO_FIXED},       // discarded up to the end of the stream
      '{8'h7F, 1'b1, 1'b1, SKIPPED_END},
      '{8'h01, 1'b0, 1'b0, NO_FIXED},       // stream ends on a distance byte
      '{8'h00, 1'b1, 1'b1, TRUNC_AT_END}
   };

   logic                        clock;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   lz77td_pkg::req_payload_type req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b1;
   lz77td_pkg::rsp_payload_type rsp_data;

   int   req_idle_pct = 24;
   int   rsp_idle_pct = 76;
   logic hold_request = 1'b0;
   int   mismatch_count = 0;
   int   checked_chunks = 0;
   int   sent_bytes = 0;
   int   streams_done = 0;

   // Decoder state as the predictor sees it.
   lz77td_pkg::phase_type token_phase = lz77td_pkg::PH_FLAG;
   logic [15:0]  copy_distance = '0;
   logic [15:0]  bytes_produced = '0;
   logic [15:0]  history_wptr = '0;
   logic [7:0]   history_bytes [lz77td_pkg::HIST_DEPTH];
   logic [7:0]   lane_bytes [lz77td_pkg::LANES];
   int           lane_fill;

   lz77td_pkg::rsp_payload_type step_chunks [$];
   lz77td_pkg::rsp_payload_type expected_chunks [$];

   lz77_token_decompressor dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Close the lanes gathered so far into one result of this byte.
   function automatic void close_chunk(input lz77td_pkg::err_code_type err);
      lz77td_pkg::rsp_payload_type chunk;
      if (step_chunks.size() >= RESULTS_PER_BYTE_MAX) return;
      chunk            = '0;
      chunk.out_byte0  = (lane_fill > 0) ? lane_bytes[0] : 8'h00;
      chunk.out_byte1  = (lane_fill > 1) ? lane_bytes[1] : 8'h00;
      chunk.out_byte2  = (lane_fill > 2) ? lane_bytes[2] : 8'h00;
      chunk.out_byte3  = (lane_fill > 3) ? lane_bytes[3] : 8'h00;
      chunk.out_count  = 3'(lane_fill);
      chunk.error_code = err;
      step_chunks.insert(step_chunks.size(), chunk);
      lane_fill = 0;
   endfunction

   // Write one decompressed byte to the history and to the next lane.
   function automatic void produce_byte(input logic [7:0] b);
      if (step_chunks.size() >= RESULTS_PER_BYTE_MAX) return;
      history_bytes[history_wptr] = b;
      history_wptr = history_wptr + 16'd1;
      if (bytes_produced != lz77td_pkg::PRODUCED_MAX) bytes_produced = bytes_produced + 16'd1;
      lane_bytes[lane_fill] = b;
      lane_fill++;
      if (lane_fill >= lz77td_pkg::LANES) close_chunk(lz77td_pkg::ERR_NONE);
   endfunction

   // Work out every result that one token byte causes.
   function automatic void decode_token_byte(input logic [7:0] b, input logic last);
      lz77td_pkg::err_code_type err;
      logic [15:0]              src;
      err = lz77td_pkg::ERR_NONE;
      lane_fill = 0;
      step_chunks.delete();
      case (token_phase)
         lz77td_pkg::PH_FLAG: begin
            if (last) err = lz77td_pkg::ERR_TRUNC;
            else if (b == lz77td_pkg::FLAG_COPY) token_phase = lz77td_pkg::PH_DHI;
            else token_phase = lz77td_pkg::PH_LIT;
         end
         lz77td_pkg::PH_LIT: begin
            produce_byte(b);
            token_phase = lz77td_pkg::PH_FLAG;
         end
         lz77td_pkg::PH_DHI: begin
            copy_distance = {b, 8'h00};
            if (last) err = lz77td_pkg::ERR_TRUNC;
            else token_phase = lz77td_pkg::PH_DLO;
         end
         lz77td_pkg::PH_DLO: begin
            copy_distance[7:0] = b;
            if (last) err = lz77td_pkg::ERR_TRUNC;
            else token_phase = lz77td_pkg::PH_LEN;
         end
         lz77td_pkg::PH_LEN: begin
            token_phase = lz77td_pkg::PH_FLAG;
            if (copy_distance == 16'd0 || copy_distance > bytes_produced) begin
               err = lz77td_pkg::ERR_DIST;
            end else begin
               // One byte at a time, so a copy may read what it has just written.
               for (int i = 0; i < int'(b); i++) begin
                  src = history_wptr - copy_distance;
                  produce_byte(history_bytes[src]);
               end
            end
         end
         default: ;
      endcase
      if (lane_fill > 0) close_chunk(lz77td_pkg::ERR_NONE);
      if (err != lz77td_pkg::ERR_NONE) begin
         close_chunk(err);
         if (!last) token_phase = lz77td_pkg::PH_SKIP;
      end
      if (last) begin
         if (step_chunks.size() == 0) close_chunk(lz77td_pkg::ERR_NONE);
         token_phase    = lz77td_pkg::PH_FLAG;
         copy_distance  = '0;
         bytes_produced = '0;
         history_wptr   = '0;
      end
      if (step_chunks.size() > 0) begin
         step_chunks[step_chunks.size() - 1].run_last   = 1'b1;
         step_chunks[step_chunks.size() - 1].stream_end = last;
      end
   endfunction

   // Offer one token byte, and queue its results once the transaction is taken.
   task automatic send_token_byte(input logic [7:0] b, input logic last,
                                  input logic fixed,
                                  input lz77td_pkg::rsp_payload_type fixed_chunk);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: b, stream_last: last};
      do @(posedge clock); while (req_stall);
      sent_bytes++;
      if (last) streams_done++;
      decode_token_byte(b, last);
      if (fixed) expected_chunks.insert(expected_chunks.size(), fixed_chunk);
      else foreach (step_chunks[i]) expected_chunks.insert(expected_chunks.size(),
                                                            step_chunks[i]);
   endtask

   task automatic send_copy(input logic [15:0] copy_dist, input logic [7:0] len,
                            input logic last);
      send_token_byte(lz77td_pkg::FLAG_COPY, 1'b0, 1'b0, NO_FIXED);
      send_token_byte(copy_dist[15:8], 1'b0, 1'b0, NO_FIXED);
      send_token_byte(copy_dist[7:0], 1'b0, 1'b0, NO_FIXED);
      send_token_byte(len, last, 1'b0, NO_FIXED);
   endtask

   // Stop offering and wait until every expected result has been taken.
   task automatic pause_until_drained(input int settle);
      req_valid <= 1'b0;
      while (expected_chunks.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // One stream: mostly well-formed tokens, some bad distances and cut-off
   // tokens, and now and then plain noise.
   task automatic random_stream();
      int          tokens;
      int          kind;
      int          cut;
      int          reach;
      logic        fin;
      logic [7:0]  flag;
      logic [15:0] copy_dist;
      logic [7:0]  len;
      tokens = $urandom_range(1, 10);
      if ($urandom_range(99) < 8) begin
         repeat (tokens * 2) send_token_byte(8'($urandom_range(255)), 1'b0, 1'b0, NO_FIXED);
         send_token_byte(8'($urandom_range(255)), 1'b1, 1'b0, NO_FIXED);
         return;
      end
      for (int k = 0; k < tokens; k++) begin
         fin  = (k == tokens - 1);
         kind = $urandom_range(99);
         if (kind < 45 || bytes_produced == 16'd0) begin
            flag = 8'($urandom_range(255));
            if (flag == lz77td_pkg::FLAG_COPY) flag = ~lz77td_pkg::FLAG_COPY;
            send_token_byte(flag, 1'b0, 1'b0, NO_FIXED);
            send_token_byte(8'($urandom_range(255)), fin, 1'b0, NO_FIXED);
         end else if (kind < 88) begin
            reach = (bytes_produced < 16'd80) ? int'(bytes_produced) : 80;
            if ($urandom_range(3) == 0) copy_dist = 16'($urandom_range(1, int'(bytes_produced)));
            else copy_dist = 16'($urandom_range(1, reach));
            if ($urandom_range(99) < 12) len = 8'($urandom_range(255));
            else len = 8'($urandom_range(12));
            send_copy(copy_dist, len, fin);
         end else if (kind < 94) begin
            if ($urandom_range(1) == 0) copy_dist = 16'h0000;
            else copy_dist = 16'($urandom_range(int'(bytes_produced) + 1, 65535));
            send_copy(copy_dist, 8'($urandom_range(255)), fin);
         end else begin
            // The stream stops in the middle of a token.
            cut = $urandom_range(2);
            send_token_byte(lz77td_pkg::FLAG_COPY, cut == 0, 1'b0, NO_FIXED);
            if (cut == 0) return;
            send_token_byte(8'($urandom_range(255)), cut == 1, 1'b0, NO_FIXED);
            if (cut == 1) return;
            send_token_byte(8'($urandom_range(255)), 1'b1, 1'b0, NO_FIXED);
            return;
         end
      end
   endtask

   // Receiver: random stalls, or one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   // Compare each result transaction with the oldest expectation.
   always @(posedge clock) begin
      lz77td_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chunks.size() == 0) begin
            mismatch_count++;
            $display("%0t: result expected none, got %h", $time, rsp_data);
         end else begin
            want = expected_chunks.pop_front();
            checked_chunks++;
            check_field("out_byte0", want.out_byte0, rsp_data.out_byte0);
            check_field("out_byte1", want.out_byte1, rsp_data.out_byte1);
            check_field("out_byte2", want.out_byte2, rsp_data.out_byte2);
            check_field("out_byte3", want.out_byte3, rsp_data.out_byte3);
            check_field("out_count", 8'(want.out_count), 8'(rsp_data.out_count));
            check_field("run_last", 8'(want.run_last), 8'(rsp_data.run_last));
            check_field("stream_end", 8'(want.stream_end), 8'(rsp_data.stream_end));
            check_field("error_code", 8'(want.error_code), 8'(rsp_data.error_code));
         end
      end
   end

   initial begin
      int   phase_start;
      logic paused_once;
      paused_once = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, with the receiver holding off long enough to fill the block.
      hold_request = 1'b1;
      foreach (DIRECTED_ROWS[r])
         send_token_byte(DIRECTED_ROWS[r].token_byte, DIRECTED_ROWS[r].last,
                         DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].want);

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            req_idle_pct = 76;
            rsp_idle_pct = 24;
         end else if (phase == 2) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         phase_start = sent_bytes;
         while (sent_bytes - phase_start < ITEMS_PER_PHASE) begin
            random_stream();
            if (!paused_once && sent_bytes - phase_start > ITEMS_PER_PHASE / 2) begin
               pause_until_drained(0);
               paused_once = 1'b1;
            end
         end
         pause_until_drained(0);
      end

      pause_until_drained(SETTLE_CYCLES);
      $display("Sent %0d token bytes in %0d streams; %0d result transactions checked.",
               sent_bytes, streams_done, checked_chunks);
      $display("Covered cut-off tokens, bad distances, skipped input and overlapping copies.");
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
